[design/u2l_pkg.sv]
// shared types, constants and byte classification helpers for the utf-8 to latin-1 core
package u2l_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned MaxRes = 3;

    localparam logic [ByteW-1:0] QMARK = 8'h3F;

    typedef logic [ByteW-1:0] byte_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_2B   = 2'd1,
        KIND_3B   = 2'd2,
        KIND_4B   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        byte_t       lead;
        logic [1:0]  count;
        byte_t       tail0;
    } hold_t;

    typedef struct packed {
        logic [MaxRes-1:0][ByteW-1:0] bytes;
        logic [1:0]                   n;
    } res_t;

    function automatic kind_t lead_kind_of(input byte_t b);
        kind_t k;
        k = KIND_NONE;
        if (b[7:5] == 3'b110) begin
            k = KIND_2B;
        end else if (b[7:4] == 4'b1110) begin
            k = KIND_3B;
        end else if (b[7:3] == 5'b11110) begin
            k = KIND_4B;
        end
        return k;
    endfunction

    function automatic logic is_cont(input byte_t b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic byte_t latin1_of(input byte_t lead, input byte_t cont);
        byte_t v;
        v = QMARK;
        if (lead[4:2] == 3'b000) begin
            v = {lead[1:0], cont[5:0]};
        end
        return v;
    endfunction

endpackage

[design/u2l_decode.sv]
// combinational decode of one byte against the held sequence state
module u2l_decode
    import u2l_pkg::*;
(
    input  byte_t in_byte,
    input  logic  in_last,
    input  hold_t st,
    output res_t  res,
    output hold_t st_next
);

    kind_t b_kind;
    kind_t t_kind;
    logic  b_cont;
    logic  b_raw;
    logic  seq_done;

    assign b_kind   = lead_kind_of(in_byte);
    assign t_kind   = lead_kind_of(st.tail0);
    assign b_cont   = is_cont(in_byte);
    assign b_raw    = !in_byte[7] || in_last || (b_kind == KIND_NONE);
    assign seq_done = (st.kind == KIND_3B) ? (st.count == 2'd1) : (st.count == 2'd2);

    always_comb begin
        res     = '0;
        st_next = st;
        case (st.kind)
            KIND_NONE: begin
                if (b_raw) begin
                    res.bytes[0] = in_byte;
                    res.n        = 2'd1;
                end else begin
                    st_next.kind  = b_kind;
                    st_next.lead  = in_byte;
                    st_next.count = 2'd0;
                end
            end
            KIND_2B: begin
                st_next.kind  = KIND_NONE;
                st_next.lead  = '0;
                st_next.count = 2'd0;
                if (b_cont) begin
                    res.bytes[0] = latin1_of(st.lead, in_byte);
                    res.n        = 2'd1;
                end else begin
                    // lead goes out raw, then the byte starts afresh
                    res.bytes[0] = st.lead;
                    if (b_raw) begin
                        res.bytes[1] = in_byte;
                        res.n        = 2'd2;
                    end else begin
                        res.n         = 2'd1;
                        st_next.kind  = b_kind;
                        st_next.lead  = in_byte;
                    end
                end
            end
            KIND_3B, KIND_4B: begin
                if (seq_done) begin
                    res.bytes[0]  = QMARK;
                    res.n         = 2'd1;
                    st_next.kind  = KIND_NONE;
                    st_next.lead  = '0;
                    st_next.count = 2'd0;
                end else if (!in_last) begin
                    if (st.count == 2'd0) begin
                        st_next.tail0 = in_byte;
                    end
                    st_next.count = st.count + 2'd1;
                end else begin
                    // buffer ends early: lead raw, then any held tail and this byte (a held two-byte pair decoded)
                    st_next.kind  = KIND_NONE;
                    st_next.lead  = '0;
                    st_next.count = 2'd0;
                    res.bytes[0]  = st.lead;
                    if (st.count == 2'd0) begin
                        res.bytes[1] = in_byte;
                        res.n        = 2'd2;
                    end else if ((t_kind == KIND_2B) && b_cont) begin
                        res.bytes[1] = latin1_of(st.tail0, in_byte);
                        res.n        = 2'd2;
                    end else begin
                        res.bytes[1] = st.tail0;
                        res.bytes[2] = in_byte;
                        res.n        = 2'd3;
                    end
                end
            end
            default: begin
                res     = '0;
                st_next = st;
            end
        endcase
    end

endmodule

[design/utf8_to_latin1_stream_core.sv]
// top level of the utf-8 to latin-1 stream transcoder
// Takes one UTF-8 byte per word on the s_ side (s_tlast marks the last byte of a
// buffer) and gives Latin-1 bytes on the m_ side, m_tlast marking the last byte that
// an input word caused. A word is taken into an input register, decoded from there
// and written into a three-byte result buffer once that buffer is free. Input words
// are accepted one per cycle as long as m_tready stays high and each causes at most
// one output byte; a word that causes two or three bytes (a failed sequence being
// replayed) keeps the result buffer busy until all its bytes are sent, and a word that
// only extends a held sequence causes none and never waits on the output side.
module utf8_to_latin1_stream_core
    import u2l_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast    // out_run_end
);

    logic                         in_valid_reg, in_valid_next;
    byte_t                        in_byte_reg;
    logic                         in_last_reg;
    hold_t                        hold_reg, hold_next;
    logic [MaxRes-1:0][ByteW-1:0] ob_bytes_reg, ob_bytes_next;
    logic [1:0]                   ob_cnt_reg, ob_cnt_next;

    res_t  dec_res;
    hold_t dec_hold;
    logic  s_accept;
    logic  draining;
    logic  ob_free;
    logic  consume;

    u2l_decode u_decode (
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .st      (hold_reg),
        .res     (dec_res),
        .st_next (dec_hold)
    );

    assign draining = (ob_cnt_reg != 2'd0) && m_tready;
    assign ob_free  = (ob_cnt_reg == 2'd0) || ((ob_cnt_reg == 2'd1) && m_tready);
    assign consume  = in_valid_reg && (ob_free || (dec_res.n == 2'd0));
    assign s_tready = !in_valid_reg || consume;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = ob_cnt_reg != 2'd0;
    assign m_tdata  = ob_bytes_reg[0];
    assign m_tlast  = ob_cnt_reg == 2'd1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
        hold_next = consume ? dec_hold : hold_reg;
        ob_bytes_next = ob_bytes_reg;
        ob_cnt_next   = ob_cnt_reg;
        if (consume && (dec_res.n != 2'd0)) begin
            ob_bytes_next = dec_res.bytes;
            ob_cnt_next   = dec_res.n;
        end else if (draining) begin
            ob_bytes_next = {8'h00, ob_bytes_reg[2], ob_bytes_reg[1]};
            ob_cnt_next   = ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            ob_cnt_reg     <= 2'd0;
            hold_reg.kind  <= KIND_NONE;
            hold_reg.lead  <= '0;
            hold_reg.count <= 2'd0;
        end else begin
            in_valid_reg   <= in_valid_next;
            ob_cnt_reg     <= ob_cnt_next;
            hold_reg.kind  <= hold_next.kind;
            hold_reg.lead  <= hold_next.lead;
            hold_reg.count <= hold_next.count;
            hold_reg.tail0 <= hold_next.tail0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        ob_bytes_reg <= ob_bytes_next;
    end

endmodule

[design/u2l_checker.sv]
// port-level checks for the utf-8 to latin-1 core, bound to the top level
module u2l_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic [1:0] run_cnt_reg;

    // words sent since the last run end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_cnt_reg <= 2'd0;
        end else if (m_tvalid && m_tready) begin
            run_cnt_reg <= m_tlast ? 2'd0 : run_cnt_reg + 2'd1;
        end
    end

    a_reset_no_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (run_cnt_reg == 2'd2) |-> m_tlast)
        else $error("more than three words for one input word");

    logic unused_in;
    assign unused_in = ^{s_tvalid, s_tdata, s_tlast};

endmodule

bind utf8_to_latin1_stream_core u2l_checker u_u2l_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
